// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; define NO_ASSERTIONS to
// compile them away.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: required property does not hold");

// expression must never be true at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed: forbidden condition seen");

`else

`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

// ===== src/lcu_pkg.sv =====
// ----------------------------------------------------------------------------
// lcu_pkg
// Shared constants and types for the life cell update engine.
// ----------------------------------------------------------------------------
`default_nettype none

package lcu_pkg;

   localparam int CMD_W     = 2;
   localparam int ROW_W     = 6;
   localparam int COL_W     = 6;
   localparam int CFG_W     = 7;
   localparam int CNT_W     = 4;
   localparam int CSR_IDX_W = 1;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 8;

   localparam int DEF_MAX_ROWS = 64;
   localparam int DEF_MAX_COLS = 64;

   localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SWAP    = 2'd2;
   localparam logic [CMD_W-1:0] CMD_READ    = 2'd3;

   localparam logic [CSR_IDX_W-1:0] IDX_GRID_ROWS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] IDX_GRID_COLS = 1'b1;

   localparam logic [CFG_W-1:0] GRID_SIZE_RESET = 7'd64;

   localparam logic [CNT_W-1:0] CNT_MAX     = 4'd8;
   localparam logic [CNT_W-1:0] CNT_BIRTH   = 4'd3;
   localparam logic [CNT_W-1:0] CNT_SURVIVE = 4'd2;

   // neighbourhood of one cell: three above, left and right, three below
   typedef struct packed {
      logic [2:0] up;
      logic [1:0] mid;
      logic [2:0] dn;
      logic       centre;
   } window_type;

   typedef struct packed {
      logic             alive;
      logic [CNT_W-1:0] count;
   } rule_out_type;

endpackage

`default_nettype wire

// ===== src/lcu_ram.sv =====
// ----------------------------------------------------------------------------
// lcu_ram
// Generic single-write, single-read RAM with bit write mask and registered
// read (read-first on a same-address collision).
// ----------------------------------------------------------------------------
`default_nettype none

module lcu_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [WIDTH-1:0]         wr_mask,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= (mem_ff[wr_addr] & ~wr_mask) | (wr_data & wr_mask);
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== src/lcu_rule.sv =====
// ----------------------------------------------------------------------------
// lcu_rule
// Neighbour count and B3/S23 rule for one cell.
// ----------------------------------------------------------------------------
`default_nettype none

module lcu_rule
   import lcu_pkg::*;
(
   input  wire window_type   win,
   output rule_out_type      res
);

   logic [CNT_W-1:0] count;

   assign count = CNT_W'(win.up[0]) + CNT_W'(win.up[1]) + CNT_W'(win.up[2])
                + CNT_W'(win.mid[0]) + CNT_W'(win.mid[1])
                + CNT_W'(win.dn[0]) + CNT_W'(win.dn[1]) + CNT_W'(win.dn[2]);

   assign res.count = count;
   assign res.alive = win.centre ? (count == CNT_SURVIVE || count == CNT_BIRTH)
                                 : (count == CNT_BIRTH);

endmodule

`default_nettype wire

// ===== src/life_cell_update_torus.sv =====
// ----------------------------------------------------------------------------
// life_cell_update_torus
// Game of Life cell engine (B3/S23) on a wrapped grid with two generations.
// ----------------------------------------------------------------------------
// One command is taken every clock. Its result is presented on rsp from
// the result register, after the stage-1 registers. The accepting edge reads
// the rows above, at and below the cell from three copies of the row RAM.
// Stage 1 then counts neighbours, applies the rule, performs the single row
// write and loads the result register. A result that is not taken holds
// back the input. Each RAM row (bank, row) has a valid flag cleared by
// reset, so a row never written reads as all dead and no clearing pass is
// needed. Grid sizes are clamped to 1..MAX_ROWS and 1..MAX_COLS; write them
// only while idle.
`default_nettype none
`include "assert_macros.svh"

module life_cell_update_torus
   import lcu_pkg::*;
#(
   parameter int MAX_ROWS = DEF_MAX_ROWS,
   parameter int MAX_COLS = DEF_MAX_COLS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request: tdata = row[5:0], column[11:6], value[12], zero[15:13]
   //          tuser = command[1:0]
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [CMD_W-1:0]      req_tuser,
   // response: tdata = cell_state[0], neighbour_count[4:1],
   //           bad_coordinate[5], zero[7:6]
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   // configuration
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CFG_W-1:0]      csr_wdata
);

   localparam int RA_W   = $clog2(MAX_ROWS);
   localparam int CA_W   = $clog2(MAX_COLS);
   // bank bit sits above the row address, so each bank spans 2**RA_W rows
   localparam int BDEPTH = 2 * (2 ** RA_W);
   localparam int BA_W   = $clog2(BDEPTH);
   localparam int RW0    = ($clog2(MAX_ROWS + 1) > CFG_W) ? $clog2(MAX_ROWS + 1) : CFG_W;
   localparam int RW     = (RW0 > ROW_W) ? RW0 : ROW_W;
   localparam int CW0    = ($clog2(MAX_COLS + 1) > CFG_W) ? $clog2(MAX_COLS + 1) : CFG_W;
   localparam int CW     = (CW0 > COL_W) ? CW0 : COL_W;

   // ------------------------------------------------------------------
   // configuration
   // ------------------------------------------------------------------
   logic [CFG_W-1:0] rows_cfg_ff;
   logic [CFG_W-1:0] cols_cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_cfg_ff <= GRID_SIZE_RESET;
         cols_cfg_ff <= GRID_SIZE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            IDX_GRID_ROWS: rows_cfg_ff <= csr_wdata;
            IDX_GRID_COLS: cols_cfg_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [RW-1:0] rows_reg;
   logic [RW-1:0] rows_use;
   logic [CW-1:0] cols_reg;
   logic [CW-1:0] cols_use;

   assign rows_reg = RW'(rows_cfg_ff);
   assign cols_reg = CW'(cols_cfg_ff);
   assign rows_use = (rows_reg == '0) ? RW'(1) :
                     (rows_reg > RW'(MAX_ROWS)) ? RW'(MAX_ROWS) : rows_reg;
   assign cols_use = (cols_reg == '0) ? CW'(1) :
                     (cols_reg > CW'(MAX_COLS)) ? CW'(MAX_COLS) : cols_reg;

   // ------------------------------------------------------------------
   // stage 0: decode, wrap and issue row reads
   // ------------------------------------------------------------------
   logic             s1_valid_ff;
   logic             s1_adv;
   logic             req_fire;
   logic             old_bank_ff;
   logic [CMD_W-1:0] req_cmd;
   logic [RW-1:0]    req_row;
   logic [CW-1:0]    req_col;
   logic             req_value;
   logic             req_bad;
   logic [RW-1:0]    up_w;
   logic [RW-1:0]    dn_w;
   logic [CW-1:0]    lf_w;
   logic [CW-1:0]    rt_w;

   assign req_cmd   = req_tuser;
   assign req_row   = RW'(req_tdata[ROW_W-1:0]);
   assign req_col   = CW'(req_tdata[ROW_W +: COL_W]);
   assign req_value = req_tdata[ROW_W + COL_W];

   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_fire   = req_tvalid && req_tready;

   assign req_bad = (req_cmd != CMD_SWAP) && (req_row >= rows_use || req_col >= cols_use);
   assign up_w    = (req_row == '0) ? rows_use - RW'(1) : req_row - RW'(1);
   assign dn_w    = (req_row + RW'(1) >= rows_use) ? '0 : req_row + RW'(1);
   assign lf_w    = (req_col == '0) ? cols_use - CW'(1) : req_col - CW'(1);
   assign rt_w    = (req_col + CW'(1) >= cols_use) ? '0 : req_col + CW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         old_bank_ff <= 1'b0;
      end else if (req_fire && req_cmd == CMD_SWAP) begin
         old_bank_ff <= ~old_bank_ff;
      end
   end

   logic [CMD_W-1:0] s1_cmd_ff;
   logic             s1_bad_ff;
   logic             s1_bank_ff;
   logic             s1_value_ff;
   logic [RA_W-1:0]  s1_up_ff;
   logic [RA_W-1:0]  s1_mid_ff;
   logic [RA_W-1:0]  s1_dn_ff;
   logic [CA_W-1:0]  s1_c_ff;
   logic [CA_W-1:0]  s1_lf_ff;
   logic [CA_W-1:0]  s1_rt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cmd_ff   <= req_cmd;
         s1_bad_ff   <= req_bad;
         s1_bank_ff  <= old_bank_ff;
         s1_value_ff <= req_value;
         s1_up_ff    <= up_w[RA_W-1:0];
         s1_mid_ff   <= req_row[RA_W-1:0];
         s1_dn_ff    <= dn_w[RA_W-1:0];
         s1_c_ff     <= req_col[CA_W-1:0];
         s1_lf_ff    <= lf_w[CA_W-1:0];
         s1_rt_ff    <= rt_w[CA_W-1:0];
      end
   end

   // ------------------------------------------------------------------
   // row RAMs: three copies, each written with every row write
   // ------------------------------------------------------------------
   logic                wr_en;
   logic [BA_W-1:0]     wr_addr;
   logic [MAX_COLS-1:0] wr_data;
   logic [MAX_COLS-1:0] wr_mask;
   logic [MAX_COLS-1:0] up_ram;
   logic [MAX_COLS-1:0] mid_ram;
   logic [MAX_COLS-1:0] dn_ram;

   lcu_ram #(.WIDTH(MAX_COLS), .DEPTH(BDEPTH)) u_ram_up (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .wr_mask (wr_mask),
      .rd_en   (req_fire),
      .rd_addr ({old_bank_ff, up_w[RA_W-1:0]}),
      .rd_data (up_ram)
   );

   lcu_ram #(.WIDTH(MAX_COLS), .DEPTH(BDEPTH)) u_ram_mid (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .wr_mask (wr_mask),
      .rd_en   (req_fire),
      .rd_addr ({old_bank_ff, req_row[RA_W-1:0]}),
      .rd_data (mid_ram)
   );

   lcu_ram #(.WIDTH(MAX_COLS), .DEPTH(BDEPTH)) u_ram_dn (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .wr_mask (wr_mask),
      .rd_en   (req_fire),
      .rd_addr ({old_bank_ff, dn_w[RA_W-1:0]}),
      .rd_data (dn_ram)
   );

   // ------------------------------------------------------------------
   // stage 1: patch rows with the latest write, apply rule, write back
   // ------------------------------------------------------------------
   logic [BDEPTH-1:0]   valid_ff;
   logic                hist_valid_ff;
   logic [BA_W-1:0]     hist_addr_ff;
   logic [CA_W-1:0]     hist_col_ff;
   logic                hist_bit_ff;
   logic                hist_full_ff;
   logic [MAX_COLS-1:0] hist_onehot;
   logic [MAX_COLS-1:0] hist_set;

   assign hist_onehot = {{(MAX_COLS-1){1'b0}}, 1'b1} << hist_col_ff;
   assign hist_set    = hist_bit_ff ? hist_onehot : '0;

   // The latest write may have landed on the same edge as this item's read,
   // so its RAM data can be stale; overlay that write. Rows never written
   // read as dead.
   function automatic logic [MAX_COLS-1:0] patch_row(
      input logic [MAX_COLS-1:0] ram_row,
      input logic                row_ok,
      input logic                hit,
      input logic                full,
      input logic [MAX_COLS-1:0] onehot,
      input logic [MAX_COLS-1:0] set_bits
   );
      logic [MAX_COLS-1:0] row;
      if (hit) begin
         row = full ? set_bits : ((ram_row & ~onehot) | set_bits);
      end else begin
         row = row_ok ? ram_row : '0;
      end
      return row;
   endfunction

   logic [BA_W-1:0]     up_addr;
   logic [BA_W-1:0]     mid_addr;
   logic [BA_W-1:0]     dn_addr;
   logic [MAX_COLS-1:0] up_row;
   logic [MAX_COLS-1:0] mid_row;
   logic [MAX_COLS-1:0] dn_row;

   assign up_addr  = {s1_bank_ff, s1_up_ff};
   assign mid_addr = {s1_bank_ff, s1_mid_ff};
   assign dn_addr  = {s1_bank_ff, s1_dn_ff};

   assign up_row  = patch_row(up_ram, valid_ff[up_addr],
                              hist_valid_ff && hist_addr_ff == up_addr,
                              hist_full_ff, hist_onehot, hist_set);
   assign mid_row = patch_row(mid_ram, valid_ff[mid_addr],
                              hist_valid_ff && hist_addr_ff == mid_addr,
                              hist_full_ff, hist_onehot, hist_set);
   assign dn_row  = patch_row(dn_ram, valid_ff[dn_addr],
                              hist_valid_ff && hist_addr_ff == dn_addr,
                              hist_full_ff, hist_onehot, hist_set);

   window_type   win;
   rule_out_type rule;

   assign win.up     = {up_row[s1_lf_ff], up_row[s1_c_ff], up_row[s1_rt_ff]};
   assign win.mid    = {mid_row[s1_lf_ff], mid_row[s1_rt_ff]};
   assign win.dn     = {dn_row[s1_lf_ff], dn_row[s1_c_ff], dn_row[s1_rt_ff]};
   assign win.centre = mid_row[s1_c_ff];

   lcu_rule u_rule (
      .win (win),
      .res (rule)
   );

   logic                rsp_valid_ff;
   logic                s1_fire;
   logic                wr_bit;
   logic                wr_full;
   logic [MAX_COLS-1:0] wr_onehot;

   assign s1_adv  = !rsp_valid_ff || rsp_tready;
   assign s1_fire = s1_valid_ff && s1_adv;

   assign wr_en     = s1_fire && !s1_bad_ff &&
                      (s1_cmd_ff == CMD_WRITE || s1_cmd_ff == CMD_COMPUTE);
   assign wr_addr   = (s1_cmd_ff == CMD_COMPUTE) ? {~s1_bank_ff, s1_mid_ff}
                                                 : {s1_bank_ff, s1_mid_ff};
   assign wr_bit    = (s1_cmd_ff == CMD_COMPUTE) ? rule.alive : s1_value_ff;
   assign wr_full   = !valid_ff[wr_addr];
   assign wr_onehot = {{(MAX_COLS-1){1'b0}}, 1'b1} << s1_c_ff;
   // first write to a row writes all of it, which clears the stale contents
   assign wr_mask   = wr_full ? '1 : wr_onehot;
   assign wr_data   = wr_bit ? wr_onehot : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         hist_valid_ff <= 1'b0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
         hist_valid_ff     <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_addr_ff <= wr_addr;
         hist_col_ff  <= s1_c_ff;
         hist_bit_ff  <= wr_bit;
         hist_full_ff <= wr_full;
      end
   end

   // ------------------------------------------------------------------
   // result register
   // ------------------------------------------------------------------
   logic             res_state;
   logic [CNT_W-1:0] res_count;
   logic             rsp_state_ff;
   logic [CNT_W-1:0] rsp_count_ff;
   logic             rsp_bad_ff;

   always_comb begin
      res_state = 1'b0;
      res_count = '0;
      unique case (s1_cmd_ff)
         CMD_WRITE: ;
         CMD_SWAP:  ;
         CMD_READ: begin
            res_state = !s1_bad_ff && win.centre;
         end
         CMD_COMPUTE: begin
            res_state = !s1_bad_ff && rule.alive;
            res_count = s1_bad_ff ? '0 : rule.count;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_state_ff <= res_state;
         rsp_count_ff <= res_count;
         rsp_bad_ff   <= s1_bad_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - CNT_W - 2){1'b0}}, rsp_bad_ff, rsp_count_ff, rsp_state_ff};

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   `ASSERT_ALWAYS(a_bad_is_blank, clock, reset, rsp_valid_ff && rsp_bad_ff |-> !rsp_state_ff && rsp_count_ff == '0)
   `ASSERT_NEVER(a_count_range, clock, reset, rsp_valid_ff && rsp_count_ff > CNT_MAX)
   `ASSERT_ALWAYS(a_swap_toggles, clock, reset, req_fire && req_cmd == CMD_SWAP |=> old_bank_ff != $past(old_bank_ff))
   `ASSERT_ALWAYS(a_row_marked, clock, reset, wr_en |=> valid_ff[$past(wr_addr)] && hist_valid_ff)

endmodule

`default_nettype wire

// ===== verif/life_cell_checker.sv =====
// ----------------------------------------------------------------------------
// life_cell_checker
// Watches the command, result and register ports of the life cell engine,
// keeps its own copy of both cell generations and the grid size, predicts
// the result of every accepted command and compares it, field by field,
// with the results in the order they leave the block.
// ----------------------------------------------------------------------------
module life_cell_checker
   import lcu_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [CMD_W-1:0]      req_tuser,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CFG_W-1:0]      csr_wdata,
   output int                         fail_count,
   output int                         pending_count,
   output int                         checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // same layout as the low bits of rsp_tdata
   typedef struct packed {
      logic             bad;
      logic [CNT_W-1:0] count;
      logic             alive;
   } cell_result_type;

   bit               life_grid [0:1][0:DEF_MAX_ROWS-1][0:DEF_MAX_COLS-1];
   bit               old_bank = 1'b0;
   logic [CFG_W-1:0] rows_reg = GRID_SIZE_RESET;
   logic [CFG_W-1:0] cols_reg = GRID_SIZE_RESET;
   cell_result_type  expected_cells [$];
   int               mismatch_count = 0;
   int               compared = 0;

   function automatic int clamp_size(input logic [CFG_W-1:0] size_value, input int limit);
      if (size_value == '0) return 1;
      if (int'(size_value) > limit) return limit;
      return int'(size_value);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   // one command against the predicted grids; updates them as the block would
   task automatic apply_command(input logic [CMD_W-1:0] cmd, input int row, input int col,
                                input bit val, output cell_result_type res);
      int rows;
      int cols;
      int nr [3];
      int nc [3];
      int count;
      bit centre;
      rows = clamp_size(rows_reg, DEF_MAX_ROWS);
      cols = clamp_size(cols_reg, DEF_MAX_COLS);
      res  = '0;
      if (cmd == CMD_SWAP) begin
         old_bank = old_bank ^ 1'b1;
      end else if (row >= rows || col >= cols) begin
         res.bad = 1'b1;
      end else if (cmd == CMD_WRITE) begin
         life_grid[old_bank][row][col] = val;
      end else if (cmd == CMD_READ) begin
         res.alive = life_grid[old_bank][row][col];
      end else begin
         // wrap literally: on narrow grids the same cell may count twice
         nr[0] = (row == 0) ? rows - 1 : row - 1;
         nr[1] = row;
         nr[2] = (row + 1 >= rows) ? 0 : row + 1;
         nc[0] = (col == 0) ? cols - 1 : col - 1;
         nc[1] = col;
         nc[2] = (col + 1 >= cols) ? 0 : col + 1;
         count = 0;
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
               if (i != 1 || j != 1) count += life_grid[old_bank][nr[i]][nc[j]];
         centre    = life_grid[old_bank][row][col];
         res.count = CNT_W'(count);
         res.alive = (count == CNT_BIRTH) || (centre && count == CNT_SURVIVE);
         life_grid[old_bank ^ 1'b1][row][col] = res.alive;
      end
   endtask

   always @(posedge clock) begin
      cell_result_type seen;
      cell_result_type want;
      cell_result_type pred;
      if (reset) begin
         foreach (life_grid[b, r, c]) life_grid[b][r][c] = 1'b0;
         old_bank = 1'b0;
         rows_reg = GRID_SIZE_RESET;
         cols_reg = GRID_SIZE_RESET;
         expected_cells.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == IDX_GRID_ROWS) rows_reg = csr_wdata;
            else cols_reg = csr_wdata;
         end
         // results leave after their commands, so retire before predicting
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata[5:0];
            if (expected_cells.size() == 0) begin
               report_mismatch($sformatf("result 0x%0h arrived with none expected", rsp_tdata));
            end else begin
               want = expected_cells.pop_front();
               compared++;
               if (seen.alive !== want.alive)
                  report_mismatch($sformatf("result %0d: cell_state %b, expected %b",
                                            compared, seen.alive, want.alive));
               if (seen.count !== want.count)
                  report_mismatch($sformatf("result %0d: neighbour_count %0d, expected %0d",
                                            compared, seen.count, want.count));
               if (seen.bad !== want.bad)
                  report_mismatch($sformatf("result %0d: bad_coordinate %b, expected %b",
                                            compared, seen.bad, want.bad));
            end
         end
         if (req_tvalid && req_tready) begin
            apply_command(req_tuser, int'(req_tdata[5:0]), int'(req_tdata[11:6]),
                          req_tdata[12], pred);
            expected_cells.push_back(pred);
         end
      end
      fail_count    <= mismatch_count;
      pending_count <= expected_cells.size();
      checked_count <= compared;
   end

endmodule

// ===== verif/tb_life_cell_update_torus.sv =====
// ----------------------------------------------------------------------------
// tb_life_cell_update_torus
// Drives the life cell engine through corner and wrap cases, then through
// random generations (write a patch, compute it, swap, read it back) mixed
// with random noise, over a range of grid sizes; the checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_life_cell_update_torus;
   timeunit 1ns;
   timeprecision 1ps;
   import lcu_pkg::*;

   localparam int ITEM_TARGET  = 1350;
   localparam int PHASE_ITEMS  = 110;
   localparam int IDLE_PCT     = 18;
   localparam int HOLD_CYCLES  = 4;
   localparam int SETTLE       = 8;
   localparam int STALL_LIMIT  = 2000;
   localparam int QUIET_PHASE  = 5;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [CMD_W-1:0]      req_tuser = CMD_WRITE;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = IDX_GRID_ROWS;
   logic [CFG_W-1:0]      csr_wdata = '0;

   int fail_count;
   int pending_count;
   int checked_count;
   bit idle_on = 1'b1;
   int sent_count = 0;
   int settings_count = 1;
   int rows_used = DEF_MAX_ROWS;
   int cols_used = DEF_MAX_COLS;
   int quiet_cycles = 0;

   // grid sizes as written to the registers, zero and all ones included
   int size_plan [12][2] = '{'{2, 2}, '{3, 3}, '{0, 0}, '{5, 4}, '{127, 127}, '{64, 64},
                            '{3, 64}, '{1, 7}, '{64, 2}, '{8, 6}, '{100, 0}, '{16, 33}};

   life_cell_update_torus dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   life_cell_checker cell_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("no transfer for %0d cycles, %0d results outstanding",
                  quiet_cycles, pending_count);
         $display("FAIL life_cell_update_torus");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_cmd(input logic [CMD_W-1:0] cmd, input int row, input int col,
                           input bit val);
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, val, 6'(col), 6'(row)};
      req_tuser  <= cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
   endtask

   // hold the sender until every result is back, then let the pipe settle
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (HOLD_CYCLES) @(posedge clock);
   endtask

   task automatic set_grid(input int rows, input int cols);
      drain_results();
      csr_we    <= 1'b1;
      csr_index <= IDX_GRID_ROWS;
      csr_wdata <= CFG_W'(rows);
      @(posedge clock);
      csr_index <= IDX_GRID_COLS;
      csr_wdata <= CFG_W'(cols);
      @(posedge clock);
      csr_we    <= 1'b0;
      rows_used = (rows == 0) ? 1 : (rows > DEF_MAX_ROWS ? DEF_MAX_ROWS : rows);
      cols_used = (cols == 0) ? 1 : (cols > DEF_MAX_COLS ? DEF_MAX_COLS : cols);
      settings_count++;
   endtask

   // write a patch, compute every cell of it, swap and read the new cells back
   task automatic run_generation();
      int wr;
      int wc;
      int r0;
      int c0;
      int density;
      wr = (rows_used <= 6) ? rows_used : $urandom_range(5, 3);
      wc = (cols_used <= 6) ? cols_used : $urandom_range(5, 3);
      r0 = $urandom_range(rows_used - 1);
      c0 = $urandom_range(cols_used - 1);
      density = $urandom_range(85, 15);
      for (int i = 0; i < wr; i++)
         for (int j = 0; j < wc; j++)
            send_cmd(CMD_WRITE, (r0 + i) % rows_used, (c0 + j) % cols_used,
                     $urandom_range(99) < density);
      for (int i = 0; i < wr; i++)
         for (int j = 0; j < wc; j++)
            send_cmd(CMD_COMPUTE, (r0 + i) % rows_used, (c0 + j) % cols_used,
                     $urandom_range(1));
      send_cmd(CMD_SWAP, $urandom_range(63), $urandom_range(63), $urandom_range(1));
      for (int i = 0; i < wr; i++)
         for (int j = 0; j < wc; j++)
            send_cmd(CMD_READ, (r0 + i) % rows_used, (c0 + j) % cols_used,
                     $urandom_range(1));
   endtask

   task automatic run_noise();
      repeat (8)
         send_cmd(CMD_W'($urandom_range(3)), $urandom_range(63), $urandom_range(63),
                  $urandom_range(1));
   endtask

   initial begin
      int phase;
      int phase_start;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corners of the full grid: each sees the other three across the wrap
      send_cmd(CMD_WRITE, 0, 0, 1'b1);
      send_cmd(CMD_WRITE, 0, 63, 1'b1);
      send_cmd(CMD_WRITE, 63, 0, 1'b1);
      send_cmd(CMD_WRITE, 63, 63, 1'b1);
      send_cmd(CMD_READ, 63, 63, 1'b0);
      send_cmd(CMD_READ, 0, 0, 1'b0);
      send_cmd(CMD_COMPUTE, 0, 0, 1'b0);
      send_cmd(CMD_COMPUTE, 63, 63, 1'b1);
      send_cmd(CMD_COMPUTE, 0, 62, 1'b0);
      send_cmd(CMD_COMPUTE, 32, 32, 1'b1);
      send_cmd(CMD_WRITE, 31, 31, 1'b0);
      send_cmd(CMD_SWAP, 63, 63, 1'b1);
      send_cmd(CMD_READ, 0, 0, 1'b0);
      send_cmd(CMD_READ, 0, 62, 1'b0);
      send_cmd(CMD_READ, 5, 5, 1'b0);
      send_cmd(CMD_SWAP, 0, 0, 1'b0);
      send_cmd(CMD_READ, 0, 63, 1'b0);

      // zero size clamps to one cell that neighbours itself eight times
      set_grid(0, 0);
      send_cmd(CMD_WRITE, 0, 0, 1'b1);
      send_cmd(CMD_COMPUTE, 0, 0, 1'b0);
      send_cmd(CMD_WRITE, 0, 1, 1'b1);
      send_cmd(CMD_READ, 1, 0, 1'b0);
      send_cmd(CMD_COMPUTE, 63, 63, 1'b1);
      send_cmd(CMD_SWAP, 0, 0, 1'b0);
      send_cmd(CMD_READ, 0, 0, 1'b0);

      phase = 0;
      while (sent_count < ITEM_TARGET) begin
         if (phase < 12) set_grid(size_plan[phase][0], size_plan[phase][1]);
         else set_grid($urandom_range(127), $urandom_range(127));
         idle_on = (phase != QUIET_PHASE);
         phase_start = sent_count;
         while (sent_count - phase_start < PHASE_ITEMS && sent_count < ITEM_TARGET) begin
            if ($urandom_range(99) < 75) run_generation();
            else run_noise();
            if ($urandom_range(99) < 8) drain_results();
         end
         phase++;
      end
      idle_on = 1'b1;

      drain_results();
      repeat (SETTLE) @(posedge clock);
      $display("covered %0d commands over %0d grid sizes, %0d results compared",
               sent_count, settings_count, checked_count);
      if (fail_count == 0) begin
         $display("PASS life_cell_update_torus");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("FAIL life_cell_update_torus");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/lcu_pkg.sv
src/lcu_ram.sv
src/lcu_rule.sv
src/life_cell_update_torus.sv
verif/life_cell_checker.sv
verif/tb_life_cell_update_torus.sv
